FILE: hdl/pvg_pkg.sv
// Package for the Poisson variate generator: shared types, constants,
// exp() tables and the MT19937 tempering function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pvg_pkg;

    localparam int MAX_DRAWS      = 64;
    localparam int RATE_FRAC_BITS = 12;
    localparam int RATE_W         = 16;
    localparam int COUNT_W        = 6;
    localparam int DRAW_W         = $clog2(MAX_DRAWS + 1);
    localparam int BIT_W          = $clog2(RATE_FRAC_BITS);

    // MT19937 constants
    localparam int          MT_N      = 624;
    localparam int          MT_M      = 397;
    localparam int          MT_AW     = $clog2(MT_N + 1);
    localparam logic [31:0] MT_MAG    = 32'h9908_B0DF;
    localparam logic [31:0] MT_MULT   = 32'd1812433253;
    localparam logic [31:0] SEED_INIT = 32'd5489;

    // Largest rate accepted: 15.0
    localparam logic [31:0] RATE_LIMIT = 32'd15 << RATE_FRAC_BITS;

    // One job handed from front to back
    typedef struct packed {
        logic        zero;
        logic [31:0] thr;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_FRAC,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_SEED0,
        B_SEED_MUL,
        B_SEED_ADD,
        B_IDLE,
        B_FETCH,
        B_TEMPER,
        B_MUL,
        B_CHECK,
        B_DONE,
        R_INIT,
        R_LOAD,
        R_RD,
        R_WR
    } back_state_t;

    // round(exp(-i) * 2^32) for i = 1..15; i = 0 is 1.0 and handled apart
    function automatic logic [31:0] exp_int(input logic [3:0] i);
        logic [31:0] v;
        case (i)
            4'd1:    v = 32'd1580030169;
            4'd2:    v = 32'd581260615;
            4'd3:    v = 32'd213833830;
            4'd4:    v = 32'd78665070;
            4'd5:    v = 32'd28939262;
            4'd6:    v = 32'd10646160;
            4'd7:    v = 32'd3916503;
            4'd8:    v = 32'd1440801;
            4'd9:    v = 32'd530041;
            4'd10:   v = 32'd194991;
            4'd11:   v = 32'd71733;
            4'd12:   v = 32'd26389;
            4'd13:   v = 32'd9708;
            4'd14:   v = 32'd3571;
            4'd15:   v = 32'd1314;
            default: v = 32'hFFFF_FFFF;
        endcase
        return v;
    endfunction

    // round(exp(-2^-k) * 2^32) for k = 1..16, indexed by k-1
    function automatic logic [31:0] exp_frac(input logic [3:0] k);
        logic [31:0] v;
        case (k)
            4'd0:    v = 32'd2605029347;
            4'd1:    v = 32'd3344923893;
            4'd2:    v = 32'd3790295335;
            4'd3:    v = 32'd4034748382;
            4'd4:    v = 32'd4162825044;
            4'd5:    v = 32'd4228380000;
            4'd6:    v = 32'd4261543595;
            4'd7:    v = 32'd4278222805;
            4'd8:    v = 32'd4286586875;
            4'd9:    v = 32'd4290775039;
            4'd10:   v = 32'd4292870656;
            4'd11:   v = 32'd4293918848;
            4'd12:   v = 32'd4294443040;
            4'd13:   v = 32'd4294705160;
            4'd14:   v = 32'd4294836226;
            default: v = 32'd4294901760;
        endcase
        return v;
    endfunction

    // MT19937 output tempering
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9D2C_5680);
        y = y ^ ((y << 15) & 32'hEFC6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/pvg_ram.sv
// Generic simple RAM: one write port, two read ports, registered reads.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pvg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

FILE: hdl/pvg_fifo.sv
// Two-entry job queue between the threshold front end and the draw engine.
// Depends on pvg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvg_fifo (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  pvg_pkg::job_t     push_job,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output pvg_pkg::job_t     pop_job
);

    pvg_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pvg_front.sv
// Front end: takes a rate, clamps it and forms exp(-rate) in Q0.32,
// one fraction bit per cycle on a single multiplier. Depends on pvg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvg_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rate_valid,
    output logic                              rate_ready,
    input  wire logic [pvg_pkg::RATE_W-1:0]   rate,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output pvg_pkg::job_t                     push_job
);

    pvg_pkg::front_state_t           state_reg, state_next;
    logic [pvg_pkg::RATE_W-1:0]      r_reg, r_next;
    logic [pvg_pkg::BIT_W-1:0]       bit_reg, bit_next;
    logic [31:0]                     thr_reg, thr_next;
    logic                            one_reg, one_next;
    logic                            zero_reg, zero_next;
    logic [pvg_pkg::RATE_W-1:0]      r_clamp;
    logic [3:0]                      ip;
    logic [3:0]                      tab_idx;
    logic [31:0]                     tab_val;
    logic [63:0]                     prod;

    assign rate_ready = (state_reg == pvg_pkg::F_IDLE);
    assign push_valid = (state_reg == pvg_pkg::F_PUSH);
    assign push_job   = '{zero: zero_reg, thr: thr_reg};

    // clamp and integer part
    always_comb
    begin
        if ({16'd0, rate} > pvg_pkg::RATE_LIMIT)
        begin
            r_clamp = pvg_pkg::RATE_W'(pvg_pkg::RATE_LIMIT);
        end
        else
        begin
            r_clamp = rate;
        end
        ip = 4'((32'(r_clamp) >> pvg_pkg::RATE_FRAC_BITS) & 32'd15);
    end

    // fraction step: table for weight 2^-(FRAC-bit)
    assign tab_idx = 4'(pvg_pkg::RATE_FRAC_BITS - 1 - int'(bit_reg));
    assign tab_val = pvg_pkg::exp_frac(tab_idx);
    assign prod    = {32'd0, thr_reg} * {32'd0, tab_val};

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        thr_next   = thr_reg;
        one_next   = one_reg;
        zero_next  = zero_reg;
        case (state_reg)
            pvg_pkg::F_IDLE:
            begin
                if (rate_valid)
                begin
                    r_next    = r_clamp;
                    zero_next = (rate == '0);
                    thr_next  = pvg_pkg::exp_int(ip);
                    one_next  = (ip == 4'd0);
                    bit_next  = pvg_pkg::BIT_W'(pvg_pkg::RATE_FRAC_BITS - 1);
                    state_next = (rate == '0) ? pvg_pkg::F_PUSH : pvg_pkg::F_FRAC;
                end
            end
            pvg_pkg::F_FRAC:
            begin
                if (r_reg[bit_reg])
                begin
                    // 1.0 times the table value is the table value
                    thr_next = one_reg ? tab_val : prod[63:32];
                    one_next = 1'b0;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = pvg_pkg::F_PUSH;
                end
            end
            pvg_pkg::F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = pvg_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = pvg_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pvg_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        thr_reg  <= thr_next;
        one_reg  <= one_next;
        zero_reg <= zero_next;
    end

endmodule
`default_nettype wire

FILE: hdl/pvg_back.sv
// Back end: MT19937 generator (seeding, regeneration, tempering) and the
// product-of-uniforms draw loop with the result register.
// Depends on pvg_pkg and pvg_ram.
`timescale 1ns / 1ps
`default_nettype none
module pvg_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [31:0]                   cfg_seed,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  pvg_pkg::job_t                      pop_job,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [pvg_pkg::COUNT_W-1:0]        count,
    output logic                               saturated
);

    localparam int AW = $clog2(pvg_pkg::MT_N);

    pvg_pkg::back_state_t           state_reg, state_next;
    logic [pvg_pkg::MT_AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]                  i_reg, i_next;
    logic [31:0]                    prev_reg, prev_next;
    logic [31:0]                    mul_reg, mul_next;
    logic [31:0]                    cur_reg, cur_next;
    logic [31:0]                    p_reg, p_next;
    logic [31:0]                    u_reg, u_next;
    logic [31:0]                    thr_reg, thr_next;
    logic [pvg_pkg::DRAW_W-1:0]     k_reg, k_next;
    logic [pvg_pkg::COUNT_W-1:0]    dcnt_reg, dcnt_next;
    logic                           dsat_reg, dsat_next;
    logic                           out_valid_reg, out_valid_next;
    logic [pvg_pkg::COUNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic                           out_sat_reg, out_sat_next;

    logic                           we;
    logic [AW-1:0]                  waddr, ra_a, ra_b;
    logic [31:0]                    wdata, rd_a, rd_b;
    logic [AW:0]                    i_plus_m;
    logic [31:0]                    y, v;
    logic [63:0]                    prod;

    pvg_ram #(
        .WIDTH (32),
        .DEPTH (pvg_pkg::MT_N)
    ) u_words (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (ra_a),
        .rdata_a (rd_a),
        .raddr_b (ra_b),
        .rdata_b (rd_b)
    );

    assign cfg_ready    = (state_reg == pvg_pkg::B_IDLE);
    assign pop_ready    = (state_reg == pvg_pkg::B_IDLE) && !cfg_valid;
    assign result_valid = out_valid_reg;
    assign count        = out_cnt_reg;
    assign saturated    = out_sat_reg;

    // twist datapath and draw multiplier
    assign i_plus_m = {1'b0, i_reg} + (AW + 1)'(pvg_pkg::MT_M);
    assign y        = {cur_reg[31], rd_a[30:0]};
    assign v        = rd_b ^ (y >> 1) ^ (y[0] ? pvg_pkg::MT_MAG : 32'd0);
    assign prod     = {32'd0, p_reg} * {32'd0, u_reg};

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        i_next         = i_reg;
        prev_next      = prev_reg;
        mul_next       = mul_reg;
        cur_next       = cur_reg;
        p_next         = p_reg;
        u_next         = u_reg;
        thr_next       = thr_reg;
        k_next         = k_reg;
        dcnt_next      = dcnt_reg;
        dsat_next      = dsat_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_cnt_next   = out_cnt_reg;
        out_sat_next   = out_sat_reg;
        we             = 1'b0;
        waddr          = i_reg;
        wdata          = v;
        ra_a           = '0;
        ra_b           = '0;
        case (state_reg)
            // seeding: word 0 is the seed itself
            pvg_pkg::B_SEED0:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = prev_reg;
                i_next     = AW'(1);
                state_next = pvg_pkg::B_SEED_MUL;
            end
            pvg_pkg::B_SEED_MUL:
            begin
                mul_next   = pvg_pkg::MT_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = pvg_pkg::B_SEED_ADD;
            end
            pvg_pkg::B_SEED_ADD:
            begin
                we        = 1'b1;
                wdata     = mul_reg + 32'(i_reg);
                prev_next = wdata;
                if (i_reg == AW'(pvg_pkg::MT_N - 1))
                begin
                    idx_next   = pvg_pkg::MT_AW'(pvg_pkg::MT_N);
                    state_next = pvg_pkg::B_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = pvg_pkg::B_SEED_MUL;
                end
            end
            pvg_pkg::B_IDLE:
            begin
                if (cfg_valid)
                begin
                    prev_next  = cfg_seed;
                    state_next = pvg_pkg::B_SEED0;
                end
                else if (pop_valid)
                begin
                    if (pop_job.zero)
                    begin
                        dcnt_next  = '0;
                        dsat_next  = 1'b0;
                        state_next = pvg_pkg::B_DONE;
                    end
                    else
                    begin
                        thr_next   = pop_job.thr;
                        k_next     = '0;
                        state_next = pvg_pkg::B_FETCH;
                    end
                end
            end
            pvg_pkg::B_FETCH:
            begin
                if (idx_reg >= pvg_pkg::MT_AW'(pvg_pkg::MT_N))
                begin
                    i_next     = '0;
                    state_next = pvg_pkg::R_INIT;
                end
                else
                begin
                    ra_a       = idx_reg[AW-1:0];
                    idx_next   = idx_reg + 1'b1;
                    state_next = pvg_pkg::B_TEMPER;
                end
            end
            pvg_pkg::B_TEMPER:
            begin
                u_next     = pvg_pkg::temper(rd_a);
                state_next = pvg_pkg::B_MUL;
            end
            pvg_pkg::B_MUL:
            begin
                p_next     = (k_reg == '0) ? u_reg : prod[63:32];
                k_next     = k_reg + 1'b1;
                state_next = pvg_pkg::B_CHECK;
            end
            pvg_pkg::B_CHECK:
            begin
                if (p_reg > thr_reg)
                begin
                    if (k_reg >= pvg_pkg::DRAW_W'(pvg_pkg::MAX_DRAWS))
                    begin
                        dcnt_next  = pvg_pkg::COUNT_W'(k_reg - 1'b1);
                        dsat_next  = 1'b1;
                        state_next = pvg_pkg::B_DONE;
                    end
                    else
                    begin
                        state_next = pvg_pkg::B_FETCH;
                    end
                end
                else
                begin
                    dcnt_next  = pvg_pkg::COUNT_W'(k_reg - 1'b1);
                    dsat_next  = 1'b0;
                    state_next = pvg_pkg::B_DONE;
                end
            end
            pvg_pkg::B_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = dcnt_reg;
                    out_sat_next   = dsat_reg;
                    state_next     = pvg_pkg::B_IDLE;
                end
            end
            // regeneration: word 0 primes the carried current word
            pvg_pkg::R_INIT:
            begin
                ra_a       = '0;
                state_next = pvg_pkg::R_LOAD;
            end
            pvg_pkg::R_LOAD:
            begin
                cur_next   = rd_a;
                state_next = pvg_pkg::R_RD;
            end
            pvg_pkg::R_RD:
            begin
                ra_a = (i_reg == AW'(pvg_pkg::MT_N - 1)) ? '0 : i_reg + 1'b1;
                if (i_plus_m >= (AW + 1)'(pvg_pkg::MT_N))
                begin
                    ra_b = AW'(i_plus_m - (AW + 1)'(pvg_pkg::MT_N));
                end
                else
                begin
                    ra_b = i_plus_m[AW-1:0];
                end
                state_next = pvg_pkg::R_WR;
            end
            pvg_pkg::R_WR:
            begin
                we       = 1'b1;
                cur_next = rd_a;
                if (i_reg == AW'(pvg_pkg::MT_N - 1))
                begin
                    idx_next   = '0;
                    state_next = pvg_pkg::B_FETCH;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = pvg_pkg::R_RD;
                end
            end
            default:
            begin
                state_next = pvg_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pvg_pkg::B_SEED0;
            prev_reg      <= pvg_pkg::SEED_INIT;
            idx_reg       <= pvg_pkg::MT_AW'(pvg_pkg::MT_N);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        mul_reg     <= mul_next;
        cur_reg     <= cur_next;
        p_reg       <= p_next;
        u_reg       <= u_next;
        thr_reg     <= thr_next;
        k_reg       <= k_next;
        dcnt_reg    <= dcnt_next;
        dsat_reg    <= dsat_next;
        out_cnt_reg <= out_cnt_next;
        out_sat_reg <= out_sat_next;
    end

endmodule
`default_nettype wire

FILE: hdl/poisson_variate_generator_core.sv
// Top level of the Poisson variate generator: front end, job queue and
// draw engine. Depends on pvg_pkg, pvg_front, pvg_fifo, pvg_back.
`timescale 1ns / 1ps
`default_nettype none
// Each rate transaction (unsigned Q4.12, clamped to 15.0) yields one Poisson
// count by Knuth's product-of-uniforms method on an internal MT19937. The
// front end loads the integer-part table value, steps through the fraction
// bits one at a time on its multiplier and then hands the job off, skipping
// the fraction steps for a zero rate; it takes its next rate only once the
// job is in the queue. A two-entry queue lets it run ahead of the draw
// engine. Each draw goes through word read, temper, multiply and compare;
// the state is regenerated every 624 draws. Zero rates return without
// drawing. After reset, and after each seed write, the generator runs a
// seeding pass; rates are still taken into the queue during that time.
// Write the seed only while the block is idle.
module poisson_variate_generator_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [31:0]                  rng_seed,
    input  wire logic                         rate_valid,
    output logic                              rate_ready,
    input  wire logic [pvg_pkg::RATE_W-1:0]   rate,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic [pvg_pkg::COUNT_W-1:0]       count,
    output logic                              saturated
);

    logic          push_valid, push_ready;
    logic          pop_valid, pop_ready;
    pvg_pkg::job_t push_job, pop_job;

    pvg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rate_valid (rate_valid),
        .rate_ready (rate_ready),
        .rate       (rate),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    pvg_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    pvg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_seed     (rng_seed),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .count        (count),
        .saturated    (saturated)
    );

    // a saturated sample always reports the draw limit less one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |->
            count == pvg_pkg::COUNT_W'(pvg_pkg::MAX_DRAWS - 1))
        else $error("saturated result with wrong count");

    // a seed write starts the seeding pass, which blocks further writes
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !cfg_ready)
        else $error("seed write did not start seeding");

endmodule
`default_nettype wire

FILE: tb/poisson_variate_generator_core_tb.sv
// Testbench for poisson_variate_generator_core: drives rate transactions and
// seed writes, predicts each Poisson count with a local MT19937 + Knuth sampler.
// Depends on pvg_pkg and the RTL of the core only.
`timescale 1ns / 1ps
module poisson_variate_generator_core_tb;

    localparam int MT_LEN = 624;
    localparam int DRAW_LIMIT = 64;
    localparam int FRAC_BITS = 12;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [31:0] rng_seed;
    logic rate_valid;
    logic rate_ready;
    logic [pvg_pkg::RATE_W-1:0] rate;
    logic result_valid;
    logic result_ready;
    logic [pvg_pkg::COUNT_W-1:0] count;
    logic saturated;

    typedef struct {
        logic [pvg_pkg::COUNT_W-1:0] count;
        logic saturated;
    } sample_t;

    // Predictor state
    logic [31:0] twister[MT_LEN];
    int unsigned twister_pos;
    sample_t expected_samples[$];

    int mismatches;
    int samples_checked;
    int saturated_seen;
    int sent_rates;
    int stall_hold;     // long receiver hold-off request, in cycles
    bit rx_idle_on;
    bit tx_idle_on;

    poisson_variate_generator_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .rng_seed(rng_seed),
        .rate_valid(rate_valid),
        .rate_ready(rate_ready),
        .rate(rate),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .count(count),
        .saturated(saturated)
    );

    always #4 clk = ~clk;

    // Exp tables: integer table Q1.32 (index 0 is 1.0), fraction table Q0.32
    function automatic logic [32:0] int_exp(input int i);
        logic [32:0] t[16];
        t = '{33'h1_0000_0000, 1580030169, 581260615, 213833830, 78665070,
              28939262, 10646160, 3916503, 1440801, 530041, 194991, 71733,
              26389, 9708, 3571, 1314};
        return t[i];
    endfunction

    function automatic logic [31:0] frac_exp(input int k);
        logic [31:0] t[16];
        t = '{32'd2605029347, 32'd3344923893, 32'd3790295335, 32'd4034748382,
              32'd4162825044, 32'd4228380000, 32'd4261543595, 32'd4278222805,
              32'd4286586875, 32'd4290775039, 32'd4292870656, 32'd4293918848,
              32'd4294443040, 32'd4294705160, 32'd4294836226, 32'd4294901760};
        return t[k];
    endfunction

    task automatic twister_seed(input logic [31:0] s);
        logic [31:0] p;
        twister[0] = s;
        for (int i = 1; i < MT_LEN; i++)
        begin
            p = twister[i-1];
            twister[i] = 32'd1812433253 * (p ^ (p >> 30)) + i;
        end
        twister_pos = MT_LEN;
    endtask

    function automatic logic [31:0] twister_draw();
        logic [31:0] y;
        logic [31:0] v;
        if (twister_pos >= MT_LEN)
        begin
            for (int i = 0; i < MT_LEN; i++)
            begin
                y = (twister[i] & 32'h8000_0000) |
                    (twister[(i+1) % MT_LEN] & 32'h7FFF_FFFF);
                v = twister[(i+397) % MT_LEN] ^ (y >> 1);
                if (y[0])
                    v ^= 32'h9908_B0DF;
                twister[i] = v;
            end
            twister_pos = 0;
        end
        y = twister[twister_pos];
        twister_pos++;
        y ^= y >> 11;
        y ^= (y << 7) & 32'h9D2C_5680;
        y ^= (y << 15) & 32'hEFC6_0000;
        y ^= y >> 18;
        return y;
    endfunction

    // Knuth sampler for one rate
    function automatic sample_t knuth_predict(input logic [15:0] lambda);
        sample_t s;
        logic [15:0] r;
        logic [63:0] thr;
        logic [63:0] prod;
        int draws;
        s.count = '0;
        s.saturated = 1'b0;
        if (lambda == 0)
            return s;
        r = (lambda > (16'd15 << FRAC_BITS)) ? (16'd15 << FRAC_BITS) : lambda;
        thr = int_exp(r >> FRAC_BITS);
        for (int b = FRAC_BITS - 1; b >= 0; b--)
            if (r[b])
                thr = (thr * frac_exp(FRAC_BITS - b - 1)) >> 32;
        prod = twister_draw();
        draws = 1;
        while (prod > thr)
        begin
            if (draws >= DRAW_LIMIT)
            begin
                s.saturated = 1'b1;
                break;
            end
            prod = (prod * twister_draw()) >> 32;
            draws++;
        end
        s.count = pvg_pkg::COUNT_W'(draws - 1);
        return s;
    endfunction

    function automatic int short_or_long_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one rate transaction and record its expected sample;
    // valid stays high between back-to-back transactions, drain() drops it
    task automatic send_rate(input logic [15:0] lambda);
        int gap;
        gap = tx_idle_on ? short_or_long_gap() : 0;
        if (gap > 0)
        begin
            rate_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rate_valid <= 1'b1;
        rate <= lambda;
        expected_samples.insert(expected_samples.size(), knuth_predict(lambda));
        @(posedge clk);
        while (!rate_ready)
            @(posedge clk);
        sent_rates++;
    endtask

    task automatic drain();
        rate_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        // engine settles; zero rates never leave work behind
        repeat (20) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        drain();
        cfg_valid <= 1'b1;
        rng_seed <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        twister_seed(s);
    endtask

    function automatic logic [15:0] random_rate();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 16'd0;
        if (pick < 12)
            return 16'($urandom_range(61441, 65535));
        if (pick < 20)
            return 16'($urandom);
        if (pick < 70)
            return 16'($urandom_range(1, 4 << FRAC_BITS));
        return 16'($urandom_range(1, 15 << FRAC_BITS));
    endfunction

    // Directed: field extremes, zero, clamp, each fraction bit, integer parts 0, 1, 2, 5, 8, 10 and 15
    task automatic test_directed();
        send_rate(16'h0000);
        send_rate(16'h0001);
        send_rate(16'hFFFF);
        send_rate(16'hF000);
        send_rate(16'hF001);
        send_rate(16'h0FFF);
        send_rate(16'h1000);
        for (int b = 0; b < 12; b++)
            send_rate(16'(1 << b) | 16'h2000);
        send_rate(16'h8000);
        send_rate(16'h5555);
        send_rate(16'hAAAA);
        drain();
    endtask

    // Seed register at its extremes, the default seed and a random value
    task automatic test_seeds();
        logic [31:0] seeds[4];
        seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'd5489, $urandom};
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            repeat (8) send_rate(random_rate());
        end
        drain();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_rate(random_rate());
    endtask

    // Receiver holds off while rates keep coming, then sender waits for drain
    task automatic test_backpressure();
        stall_hold = 400;
        repeat (8) send_rate(16'($urandom_range(1, 3 << FRAC_BITS)));
        drain();
    endtask

    // Result receiver with random stalls and an optional long hold-off
    initial
    begin
        result_ready = 1'b0;
        stall_hold = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_hold > 0)
            begin
                result_ready <= 1'b0;
                stall_hold--;
            end
            else if (rx_idle_on && $urandom_range(0, 9) < 3)
                result_ready <= 1'b0;
            else
                result_ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: count=%0d sat=%0b",
                             count, saturated);
            end
            else
            begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (saturated)
                    saturated_seen++;
                if (count !== want.count || saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: count exp %0d got %0d, sat exp %0b got %0b",
                                 want.count, count, want.saturated, saturated);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        rng_seed = 32'd0;
        rate_valid = 1'b0;
        rate = '0;
        mismatches = 0;
        samples_checked = 0;
        saturated_seen = 0;
        sent_rates = 0;
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        twister_seed(32'd5489);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        test_seeds();
        test_backpressure();
        test_random(480);
        write_seed($urandom);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random(60);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random(420);
        drain();

        $display("Checked %0d samples (%0d saturated) over %0d rates and 5 seeds.",
                 samples_checked, saturated_seen, sent_rates);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
